// ===== design/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg
// Shared sizes, codes and controller/datapath interface types for the
// depth/age replacement hash table.
// ----------------------------------------------------------------------------
package htd_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int ENTRIES      = 1 << INDEX_BITS;

    localparam int KEY_W        = 64;
    localparam int MOVE_W       = 16;
    localparam int DEPTH_W      = 8;
    localparam int AGE_W        = 8;
    localparam int PAYLOAD_W    = 32;
    localparam int REC_W        = PAYLOAD_W + MOVE_W + DEPTH_W + AGE_W;
    localparam int ENTRY_W      = KEY_W + REC_W;
    localparam int IN_DATA_W    = 120;
    localparam int OUT_DATA_W   = 64;

    localparam logic OP_READ = 1'b0;
    localparam logic OP_SAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } htd_state_t;

    typedef struct packed {
        logic clear_wr;   // write zeros at the sweep counter
        logic capture;    // take the input item, issue the table read
        logic save_eval;  // write back the entry if replacement allows
        logic load_out;   // load the result register
    } htd_cmd_t;

    typedef struct packed {
        logic clear_last; // sweep counter at last entry
        logic is_save;    // captured item is a save
        logic out_free;   // result register can take a new result
    } htd_status_t;

endpackage

// ===== design/htd_ram.sv =====
// ----------------------------------------------------------------------------
// htd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/htd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htd_ctrl
// Controller: clearing sweep after reset, then one item at a time through
// capture and evaluate.
// ----------------------------------------------------------------------------
module htd_ctrl
    import htd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  htd_status_t status,
    output htd_cmd_t    cmd
);

    htd_state_t state_reg;
    htd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.is_save || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EVAL:
            begin
                cmd.save_eval = status.is_save;
                // a read result waits here until the result register frees
                cmd.load_out  = !status.is_save && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/htd_dp.sv =====
// ----------------------------------------------------------------------------
// htd_dp
// Datapath: item capture, table RAM, replacement decision, age register,
// clearing counter and result register.
// ----------------------------------------------------------------------------
module htd_dp
    import htd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [AGE_W-1:0]      cfg_wr_data,
    input  htd_cmd_t              cmd,
    output htd_status_t           status
);

    logic [KEY_W-1:0]      in_key;
    logic [MOVE_W-1:0]     in_move;
    logic [DEPTH_W-1:0]    in_depth;
    logic [PAYLOAD_W-1:0]  in_payload;

    assign in_key     = s_tdata[63:0];
    assign in_move    = s_tdata[79:64];
    assign in_depth   = s_tdata[87:80];
    assign in_payload = s_tdata[119:88];

    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [MOVE_W-1:0]     move_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [PAYLOAD_W-1:0]  payload_reg;
    logic [AGE_W-1:0]      age_reg;
    logic [INDEX_BITS-1:0] clr_cnt_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= s_tuser;
            key_reg     <= in_key;
            move_reg    <= in_move;
            depth_reg   <= in_depth;
            payload_reg <= in_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            age_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // table RAM: {key, age, depth, move, payload}
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    htd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (in_key[INDEX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    logic [KEY_W-1:0]     old_key;
    logic [AGE_W-1:0]     old_age;
    logic [DEPTH_W-1:0]   old_depth;
    logic [MOVE_W-1:0]    old_move;
    logic [PAYLOAD_W-1:0] old_payload;
    logic                 match;
    logic                 replace;
    logic [MOVE_W-1:0]    new_move;

    assign old_key     = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign old_age     = ram_rdata[63:56];
    assign old_depth   = ram_rdata[55:48];
    assign old_move    = ram_rdata[47:32];
    assign old_payload = ram_rdata[31:0];

    assign match   = (old_key == key_reg);
    assign replace = match
                  || ($signed(old_depth) <= $signed(depth_reg))
                  || (old_age != age_reg);
    // keep the stored move when the same position is saved without one
    assign new_move = (match && (move_reg == '0)) ? old_move : move_reg;

    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.save_eval && replace;
            ram_waddr = key_reg[INDEX_BITS-1:0];
            ram_wdata = {key_reg, age_reg, depth_reg, new_move, payload_reg};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            hit_reg      <= match;
            out_data_reg <= match ? {old_payload, old_age, old_depth, old_move}
                                  : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = out_data_reg;

    assign status.clear_last = (clr_cnt_reg == {INDEX_BITS{1'b1}});
    assign status.is_save    = (op_reg == OP_SAVE);
    assign status.out_free   = !out_valid_reg || m_tready;

endmodule

// ===== design/hash_table_with_depth_age_replace.sv =====
// ----------------------------------------------------------------------------
// hash_table_with_depth_age_replace
// Direct-mapped transposition table with depth-preferred, age-aware
// replacement; lookups return the stored record on a key match.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            contents
//  s_*       in    s_tvalid/s_tready    lookup (tuser=0) or save (tuser=1)
//  m_*       out   m_tvalid/m_tready    one result per lookup
//  cfg_*     in    cfg_wr_en            current_age
//
//  Each item is captured with its table read issued, then evaluated to write
//  back or load the result register; no new item is taken until it is done.
//  After reset a clearing sweep writes zeros to all 2^INDEX_BITS entries,
//  one per cycle; s_tready stays low until it is done.
//  A lookup result that finds the result register full waits in place and
//  holds off the next item; a save never waits on the output side.
// ----------------------------------------------------------------------------
module hash_table_with_depth_age_replace
    import htd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // key, best_move, search_depth, payload
    input  logic                  s_tuser,  // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // found_move, found_depth, found_age,
                                            // found_payload
    output logic                  m_tuser,  // hit
    input  logic                  cfg_wr_en,
    input  logic [AGE_W-1:0]      cfg_wr_data // current_age
);

    htd_cmd_t    cmd;
    htd_status_t status;

    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

    // no transfer accepted while the sweep is running
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !s_tready)
        else $error("input ready during clearing sweep");

    // one item at a time: the cycle after a transfer is evaluation
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result register overwritten");

    // a save never produces a result
    a_save_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.save_eval && cmd.load_out))
        else $error("save produced a result");

endmodule

// ===== tb/tb_hash_table_with_depth_age_replace.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_table_with_depth_age_replace
// Self-checking bench for the depth/age replacement hash table. A directed
// table covers key zero, extreme fields, move keeping and refused saves.
// Random phases follow, one age per phase. Keys are drawn from small pools
// so that entries collide and replacement gets exercised. A scoreboard mirror
// of the table predicts every lookup. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_hash_table_with_depth_age_replace;
    import htd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 206;

    typedef struct packed {
        logic                  op;
        logic [KEY_W-1:0]      key;
        logic [MOVE_W-1:0]     mv;
        logic [DEPTH_W-1:0]    depth;
        logic [PAYLOAD_W-1:0]  payload;
    } probe_t;

    typedef struct packed {
        logic                  hit;
        logic [MOVE_W-1:0]     mv;
        logic [DEPTH_W-1:0]    depth;
        logic [AGE_W-1:0]      age;
        logic [PAYLOAD_W-1:0]  payload;
    } lookup_t;

    typedef struct packed {
        probe_t  p;
        logic    typed;
        lookup_t want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [AGE_W-1:0]      cfg_wr_data;

    // mirror of the table contents and the age register
    logic [KEY_W-1:0] tt_key [0:ENTRIES-1];
    logic [REC_W-1:0] tt_rec [0:ENTRIES-1];
    logic [AGE_W-1:0] age_reg;

    lookup_t  pending_lookups[$];
    dir_row_t dir_rows[$];

    logic [INDEX_BITS-1:0]       idx_pool [0:7];
    logic [KEY_W-INDEX_BITS-1:0] hi_pool  [0:3];

    int  mismatches;
    int  cycles;
    int  hold_left;
    int  rx_gap_left;
    bit  idle_on;

    hash_table_with_depth_age_replace uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
        mismatches = mismatches + 1;
    endtask

    // Updates the mirror; returns 1 with the lookup outcome for a read.
    function automatic bit tt_apply(input probe_t p, output lookup_t r);
        logic [INDEX_BITS-1:0] idx;
        logic [KEY_W-1:0]      old_k;
        logic [REC_W-1:0]      old_r;
        logic [MOVE_W-1:0]     mv;
        bit                    match;
        idx   = p.key[INDEX_BITS-1:0];
        old_k = tt_key[idx];
        old_r = tt_rec[idx];
        match = (old_k == p.key);
        r     = '0;
        if (p.op == OP_READ)
        begin
            if (match)
            begin
                r.hit     = 1'b1;
                r.mv      = old_r[47:32];
                r.depth   = old_r[55:48];
                r.age     = old_r[63:56];
                r.payload = old_r[31:0];
            end
            return 1'b1;
        end
        if (match || $signed(old_r[55:48]) <= $signed(p.depth) || old_r[63:56] != age_reg)
        begin
            mv = (match && p.mv == '0) ? old_r[47:32] : p.mv;
            tt_key[idx] = p.key;
            tt_rec[idx] = {age_reg, p.depth, mv, p.payload};
        end
        return 1'b0;
    endfunction

    task automatic offer(input probe_t p, input logic typed, input lookup_t typed_want);
        lookup_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= {p.payload, p.depth, p.mv, p.key};
        s_tuser  <= p.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (tt_apply(p, want))
            pending_lookups.push_back(typed ? typed_want : want);
    endtask

    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // all lookups answered, then a wait for a save still in flight
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_age(input logic [AGE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        age_reg = v;
    endtask

    task automatic add_row(input logic op, input logic [KEY_W-1:0] key,
                           input logic [MOVE_W-1:0] mv, input logic [DEPTH_W-1:0] depth,
                           input logic [PAYLOAD_W-1:0] payload, input logic typed,
                           input lookup_t want);
        dir_row_t row;
        row.p.op      = op;
        row.p.key     = key;
        row.p.mv      = mv;
        row.p.depth   = depth;
        row.p.payload = payload;
        row.typed     = typed;
        row.want      = want;
        dir_rows.push_back(row);
    endtask

    function automatic probe_t gen_probe();
        probe_t p;
        p.op = $urandom_range(0, 1) ? OP_SAVE : OP_READ;
        if ($urandom_range(0, 99) < 15)
            p.key = {$urandom, $urandom};
        else
            p.key = {hi_pool[$urandom_range(0, 3)], idx_pool[$urandom_range(0, 7)]};
        p.mv = ($urandom_range(0, 3) == 0) ? '0 : MOVE_W'($urandom);
        case ($urandom_range(0, 5))
            0:       p.depth = 8'h80;
            1:       p.depth = 8'h7F;
            2:       p.depth = DEPTH_W'($urandom_range(0, 6)) - 8'd3;
            default: p.depth = DEPTH_W'($urandom);
        endcase
        p.payload = $urandom;
        return p;
    endfunction

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        m_tready    = 1'b0;
        rx_gap_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (rx_gap_left > 0)
            begin
                m_tready <= 1'b0;
                rx_gap_left = rx_gap_left - 1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                rx_gap_left = $urandom_range(0, 7);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("unexpected lookup result", m_tdata, '0);
            else
            begin
                want = pending_lookups.pop_front();
                if (m_tuser !== want.hit)
                    report_mismatch("hit", 64'(m_tuser), 64'(want.hit));
                if (m_tdata[15:0] !== want.mv)
                    report_mismatch("found_move", 64'(m_tdata[15:0]), 64'(want.mv));
                if (m_tdata[23:16] !== want.depth)
                    report_mismatch("found_depth", 64'(m_tdata[23:16]), 64'(want.depth));
                if (m_tdata[31:24] !== want.age)
                    report_mismatch("found_age", 64'(m_tdata[31:24]), 64'(want.age));
                if (m_tdata[63:32] !== want.payload)
                    report_mismatch("found_payload", 64'(m_tdata[63:32]),
                                    64'(want.payload));
            end
        end
    end

    initial
    begin
        logic [AGE_W-1:0] phase_age [0:PHASES-1];
        lookup_t          z;
        lookup_t          w;
        int               drain;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_READ;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        mismatches  = 0;
        cycles      = 0;
        hold_left   = 0;
        idle_on     = 1'b0;
        age_reg     = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tt_key[i] = '0;
            tt_rec[i] = '0;
        end

        z = '0;
        // read key zero on an untouched entry: hit with an empty record
        w = z; w.hit = 1'b1;
        add_row(OP_READ, 64'h0, 16'h0, 8'h0, 32'h0, 1'b1, w);
        add_row(OP_READ, '1, 16'hFFFF, 8'h7F, '1, 1'b1, z);
        add_row(OP_READ, 64'h8000_0000_0000_0000, 16'h0, 8'h0, 32'h0, 1'b1, z);
        add_row(OP_SAVE, '1, 16'hFFFF, 8'h7F, '1, 1'b0, z);
        w = '1; w.depth = 8'h7F;
        add_row(OP_READ, '1, 16'h0, 8'h0, 32'h0, 1'b1, w);
        // shallower save, same age, other key: refused
        add_row(OP_SAVE, 64'h0001_0000_0000_FFFF, 16'h1234, 8'h80, 32'h5555_AAAA, 1'b0, z);
        add_row(OP_READ, 64'h0001_0000_0000_FFFF, 16'h0, 8'h0, 32'h0, 1'b1, z);
        add_row(OP_READ, '1, 16'h0, 8'h0, 32'h0, 1'b0, z);
        // same key with no move keeps the stored move
        add_row(OP_SAVE, '1, 16'h0, 8'h80, 32'h0, 1'b0, z);
        w = z; w.hit = 1'b1; w.mv = 16'hFFFF; w.depth = 8'h80; w.age = 8'hFF;
        add_row(OP_READ, '1, 16'h0, 8'h0, 32'h0, 1'b1, w);
        add_row(OP_SAVE, 64'h8000_0000_0000_0001, 16'h0001, 8'h00, 32'h1, 1'b0, z);
        add_row(OP_READ, 64'h8000_0000_0000_0001, 16'h0, 8'h0, 32'h0, 1'b0, z);
        add_row(OP_SAVE, 64'h4000_0000_0000_0001, 16'h0002, 8'hFF, 32'h2, 1'b0, z);
        add_row(OP_READ, 64'h4000_0000_0000_0001, 16'h0, 8'h0, 32'h0, 1'b1, z);
        add_row(OP_READ, 64'h1, 16'h0, 8'h0, 32'h0, 1'b1, z);
        add_row(OP_SAVE, 64'h0, 16'h0, 8'h00, 32'h0, 1'b0, z);
        w = z; w.hit = 1'b1; w.age = 8'hFF;
        add_row(OP_READ, 64'h0, 16'h0, 8'h0, 32'h0, 1'b1, w);
        add_row(OP_SAVE, 64'hA5A5_5A5A_0F0F_1234, 16'h8001, 8'h01, 32'h8000_0001, 1'b0, z);
        add_row(OP_READ, 64'hA5A5_5A5A_0F0F_1234, 16'h0, 8'h0, 32'h0, 1'b0, z);
        add_row(OP_READ, 64'h5A5A_A5A5_F0F0_1234, 16'h0, 8'h0, 32'h0, 1'b1, z);

        phase_age[0] = 8'h00;   // wraps from 8'hFF
        phase_age[1] = 8'h01;
        phase_age[2] = 8'h01;   // same age again: for entries saved in phase 1, only key match or depth decides
        phase_age[3] = AGE_W'($urandom);
        phase_age[4] = 8'h7F;
        phase_age[5] = 8'h80;
        phase_age[6] = 8'hFF;
        phase_age[7] = 8'h00;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_age(8'hFF);

        foreach (dir_rows[i])
            offer(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            set_age(phase_age[ph]);
            idle_on = (ph % 3 != 1) && (ph != PHASES - 1);
            foreach (idx_pool[j])
                idx_pool[j] = INDEX_BITS'($urandom);
            foreach (hi_pool[j])
                hi_pool[j] = {$urandom, 16'($urandom)};
            if (ph == 0)
                hi_pool[0] = '0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 40)
                begin
                    // long hold-off on the result side; keep offering lookups
                    hold_left = 300;
                    for (int k = 0; k < 12; k++)
                    begin
                        offer('{OP_READ, {hi_pool[k % 4], idx_pool[k % 8]}, 16'h0,
                                8'h0, 32'h0}, 1'b0, z);
                    end
                end
                if (ph == 3 && n == 100)
                    wait_quiet();
                if (idle_on && $urandom_range(0, 5) == 0)
                    pause_sender($urandom_range(1, 8));
                offer(gen_probe(), 1'b0, z);
            end
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_lookups.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (pending_lookups.size() != 0)
            report_mismatch("lookup results missing", 64'(pending_lookups.size()), '0);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
